// ----- sv/ppfa_pkg.sv -----
`timescale 1ns / 1ps
package ppfa_pkg;

  localparam int SUM_W     = 48;
  localparam int CNT_W     = 32;
  localparam int PHASE_W   = 32;
  localparam int CHAN_W    = 6;
  localparam int SAMPLE_W  = 16;
  localparam int RBIN_W    = 10;
  localparam int NBINS_W   = 11;
  localparam int BIN_MAX_W = 12;  // widest bin index the design supports

  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [2:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_WINDOW_START = 3'd1,
    REG_WINDOW_END   = 3'd2,
    REG_BIN_SCALE    = 3'd3,
    REG_BINS_IN_USE  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_step;
    logic [PHASE_W-1:0] window_start;
    logic [PHASE_W-1:0] window_end;
    logic [31:0]        bin_scale;
    logic [NBINS_W-1:0] bins_in_use;
  } cfg_t;

  typedef struct packed {
    logic                       mode;
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       step_end;
    logic [RBIN_W-1:0]          read_bin;
    logic                       in_window;
    logic [BIN_MAX_W-1:0]       bin;
    logic                       new_pulse;
    logic [CNT_W-1:0]           pulses;
  } item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] bin_sum;
    logic [CNT_W-1:0]        bin_count;
    logic                    in_window;
    logic [RBIN_W-1:0]       current_bin;
    logic                    new_pulse;
    logic [CNT_W-1:0]        pulses_seen;
  } res_t;

endpackage

// ----- sv/ppfa_ram.sv -----
`timescale 1ns / 1ps
module ppfa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ppfa_queue.sv -----
`timescale 1ns / 1ps
module ppfa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;

  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- sv/ppfa_front.sv -----
`timescale 1ns / 1ps
module ppfa_front
  import ppfa_pkg::*;
#(
  parameter int MAX_BINS = 1024,
  parameter int QDEPTH   = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cfg_t                        cfg,
  input  logic                        clearing,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [CHAN_W-1:0]           in_chan,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  input  logic                        in_step_end,
  input  logic [RBIN_W-1:0]           in_read_bin,
  input  logic [$clog2(QDEPTH+1)-1:0] q_count,
  output logic                        q_push,
  output item_t                       q_item
);

  localparam int BIN_W = $clog2(MAX_BINS);
  localparam logic [15:0] MAX_M1 = 16'(MAX_BINS - 1);
  localparam logic [15:0] MAX_NB = 16'(MAX_BINS);

  logic [PHASE_W-1:0] phase;
  logic               v1, v2;
  item_t              it1, it2;
  logic [PHASE_W-1:0] diff1;
  logic [15:0]        prod_hi2;
  logic [BIN_W-1:0]   last_bin;
  logic               last_valid;
  logic [CNT_W-1:0]   pulse_total;

  logic               accept;
  logic [63:0]        prod;
  logic [15:0]        nb_m1, bin16;
  logic [BIN_W-1:0]   bin;
  logic               upd, pulse;
  logic [CNT_W-1:0]   pulse_total_next;

  // room counts items already in the two front stages
  assign in_ready = !clearing && ((32'(q_count) + 32'(v1) + 32'(v2)) < QDEPTH);
  assign accept   = in_valid && in_ready;
  assign prod     = 64'(diff1) * 64'(cfg.bin_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      if (accept && in_mode == MODE_ACCUM && in_step_end) begin
        phase <= phase + cfg.phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it1.mode      <= in_mode;
      it1.chan      <= in_chan;
      it1.sample    <= in_sample;
      it1.step_end  <= in_step_end;
      it1.read_bin  <= in_read_bin;
      it1.in_window <= (phase >= cfg.window_start) && (phase <= cfg.window_end);
      it1.bin       <= '0;
      it1.new_pulse <= 1'b0;
      it1.pulses    <= '0;
      diff1         <= phase - cfg.window_start;
    end
    it2      <= it1;
    prod_hi2 <= prod[63:48];
  end

  always_comb begin
    if (cfg.bins_in_use == '0) begin
      nb_m1 = '0;
    end else if (16'(cfg.bins_in_use) > MAX_NB) begin
      nb_m1 = MAX_M1;
    end else begin
      nb_m1 = 16'(cfg.bins_in_use) - 16'd1;
    end
    if (!it2.in_window) begin
      bin16 = '0;
    end else if (prod_hi2 > nb_m1) begin
      bin16 = nb_m1;
    end else begin
      bin16 = prod_hi2;
    end
    bin   = bin16[BIN_W-1:0];
    upd   = v2 && it2.mode == MODE_ACCUM && it2.step_end && it2.in_window;
    pulse = upd && last_valid && (bin < last_bin);
    pulse_total_next = (pulse && pulse_total != '1) ? pulse_total + 1'b1 : pulse_total;

    q_push           = v2;
    q_item           = it2;
    q_item.bin       = BIN_MAX_W'(bin);
    q_item.new_pulse = pulse;
    q_item.pulses    = pulse_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_bin    <= '0;
      last_valid  <= 1'b0;
      pulse_total <= '0;
    end else begin
      pulse_total <= pulse_total_next;
      if (upd) begin
        last_bin   <= bin;
        last_valid <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/ppfa_back.sv -----
`timescale 1ns / 1ps
module ppfa_back
  import ppfa_pkg::*;
#(
  parameter int CHANNELS = 64,
  parameter int MAX_BINS = 1024,
  parameter int ODEPTH   = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        clearing,
  input  logic                        q_valid,
  input  item_t                       q_item,
  output logic                        q_pop,
  input  logic [$clog2(ODEPTH+1)-1:0] o_count,
  output logic                        o_push,
  output res_t                        o_res
);

  localparam int SUM_DEPTH = CHANNELS * MAX_BINS;
  localparam int SADDR_W   = $clog2(SUM_DEPTH);
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam logic [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

  logic [SADDR_W-1:0] clr_addr;

  logic               wv, wchan_ok;
  item_t              wit;
  logic [SADDR_W-1:0] wsaddr;
  logic [BIN_W-1:0]   wcaddr;

  logic               chan_ok;
  logic [BIN_W-1:0]   bin_sel;
  logic [SADDR_W-1:0] saddr;

  logic               s_we, c_we;
  logic [SADDR_W-1:0] s_waddr;
  logic [BIN_W-1:0]   c_waddr;
  logic [SUM_W-1:0]   s_wdata, s_rdata;
  logic [CNT_W-1:0]   c_wdata, c_rdata;

  logic               sfw_v, cfw_v;
  logic [SADDR_W-1:0] sfw_addr;
  logic [BIN_W-1:0]   cfw_addr;
  logic [SUM_W-1:0]   sfw_data;
  logic [CNT_W-1:0]   cfw_data;

  logic [SUM_W-1:0]   sum_old;
  logic [CNT_W-1:0]   cnt_old;
  logic [SUM_W:0]     s49;
  logic [SUM_W-1:0]   sum_new;
  logic [CNT_W-1:0]   cnt_new;
  logic               rd_ok;

  // profile and count stores are zeroed by a sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == SADDR_W'(SUM_DEPTH - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign q_pop   = q_valid && !clearing && ((32'(o_count) + 32'(wv)) < ODEPTH);
  assign chan_ok = 32'(q_item.chan) < CHANNELS;
  assign bin_sel = (q_item.mode == MODE_READ) ? BIN_W'(q_item.read_bin)
                                              : q_item.bin[BIN_W-1:0];
  assign saddr   = SADDR_W'(32'(q_item.chan) * MAX_BINS + 32'(bin_sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else begin
      wv <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    wit      <= q_item;
    wchan_ok <= chan_ok;
    wsaddr   <= saddr;
    wcaddr   <= bin_sel;
  end

  // forward the write of the previous cycle; the RAM returns old data then
  assign sum_old = (sfw_v && sfw_addr == wsaddr) ? sfw_data : s_rdata;
  assign cnt_old = (cfw_v && cfw_addr == wcaddr) ? cfw_data : c_rdata;

  always_comb begin
    s49 = {sum_old[SUM_W-1], sum_old} + (SUM_W+1)'(wit.sample);
    if (s49[SUM_W] != s49[SUM_W-1]) begin
      sum_new = s49[SUM_W] ? SUM_MIN[SUM_W-1:0] : SUM_MAX[SUM_W-1:0];
    end else begin
      sum_new = s49[SUM_W-1:0];
    end
    cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;

    s_we    = clearing || (wv && wit.mode == MODE_ACCUM && wit.in_window && wchan_ok);
    s_waddr = clearing ? clr_addr : wsaddr;
    s_wdata = clearing ? '0 : sum_new;
    c_we    = (clearing && (32'(clr_addr) < MAX_BINS)) ||
              (wv && wit.mode == MODE_ACCUM && wit.step_end && wit.in_window);
    c_waddr = clearing ? clr_addr[BIN_W-1:0] : wcaddr;
    c_wdata = clearing ? '0 : cnt_new;

    rd_ok = wit.mode == MODE_READ && wchan_ok && (32'(wit.read_bin) < MAX_BINS);
    o_push            = wv;
    o_res.bin_sum     = rd_ok ? sum_old : '0;
    o_res.bin_count   = rd_ok ? cnt_old : '0;
    o_res.in_window   = wit.in_window;
    o_res.current_bin = wit.bin[RBIN_W-1:0];
    o_res.new_pulse   = wit.new_pulse;
    o_res.pulses_seen = wit.pulses;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sfw_v <= 1'b0;
      cfw_v <= 1'b0;
    end else begin
      sfw_v <= s_we;
      cfw_v <= c_we;
    end
  end

  always_ff @(posedge clk) begin
    sfw_addr <= s_waddr;
    sfw_data <= s_wdata;
    cfw_addr <= c_waddr;
    cfw_data <= c_wdata;
  end

  ppfa_ram #(.WIDTH(SUM_W), .DEPTH(SUM_DEPTH)) u_sums (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (saddr),
    .rdata (s_rdata)
  );

  ppfa_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_counts (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (bin_sel),
    .rdata (c_rdata)
  );

endmodule

// ----- sv/pulsar_phase_folding_accumulator_top.sv -----
`timescale 1ns / 1ps
// Epoch-folding profile accumulator. Takes one request per cycle while
// s_tready is high and returns one result per request; each request passes
// two front stages, the queue, the RAM read and the output queue before its
// result is offered. The rate is set by the profile sum RAM read-modify-write,
// which is kept at one per cycle by forwarding the previous cycle's write.
// After reset the sum and count RAMs are zeroed by a sweep over the
// CHANNELS*MAX_BINS sum entries (65536 by default), during which s_tready
// stays low; APB writes are taken throughout. Reprogram only while no request
// is outstanding. Sums and counts are read back with mode 1; the host divides
// sum by count.
module pulsar_phase_folding_accumulator_top
  import ppfa_pkg::*;
#(
  parameter int CHANNELS = 64,
  parameter int MAX_BINS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // channel[5:0], sample[21:6], read_bin[31:22]
  input  logic         s_tlast,   // step_end
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // bin_sum[47:0], bin_count[79:48], in_window[80],
                                  // current_bin[90:81], new_pulse[91],
                                  // pulses_seen[123:92], zero[127:124]
);

  localparam int QDEPTH = 4;
  localparam int ODEPTH = 4;

  cfg_t     cfg;
  reg_idx_t widx;
  logic     cfg_wr;

  logic                        clearing;
  logic                        q_push, q_pop;
  item_t                       q_in, q_out;
  logic [$clog2(QDEPTH+1)-1:0] q_count;
  logic                        o_push, o_pop;
  res_t                        o_in, o_out;
  logic [$clog2(ODEPTH+1)-1:0] o_count;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step   <= '0;
      cfg.window_start <= '0;
      cfg.window_end   <= '1;
      cfg.bin_scale    <= 32'd67108864;
      cfg.bins_in_use  <= 11'd1024;
    end else if (cfg_wr) begin
      case (widx)
        REG_PHASE_STEP:   cfg.phase_step   <= pwdata;
        REG_WINDOW_START: cfg.window_start <= pwdata;
        REG_WINDOW_END:   cfg.window_end   <= pwdata;
        REG_BIN_SCALE:    cfg.bin_scale    <= pwdata;
        REG_BINS_IN_USE:  cfg.bins_in_use  <= pwdata[NBINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_PHASE_STEP:   prdata = cfg.phase_step;
      REG_WINDOW_START: prdata = cfg.window_start;
      REG_WINDOW_END:   prdata = cfg.window_end;
      REG_BIN_SCALE:    prdata = cfg.bin_scale;
      REG_BINS_IN_USE:  prdata = 32'(cfg.bins_in_use);
      default:          prdata = '0;
    endcase
  end

  ppfa_front #(.MAX_BINS(MAX_BINS), .QDEPTH(QDEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .clearing    (clearing),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_chan     (s_tdata[5:0]),
    .in_sample   (s_tdata[21:6]),
    .in_step_end (s_tlast),
    .in_read_bin (s_tdata[31:22]),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_item      (q_in)
  );

  ppfa_queue #(.WIDTH($bits(item_t)), .DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .count     (q_count)
  );

  ppfa_back #(.CHANNELS(CHANNELS), .MAX_BINS(MAX_BINS), .ODEPTH(ODEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_valid  (q_count != '0),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .o_count  (o_count),
    .o_push   (o_push),
    .o_res    (o_in)
  );

  ppfa_queue #(.WIDTH($bits(res_t)), .DEPTH(ODEPTH)) u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (o_push),
    .push_data (o_in),
    .pop       (o_pop),
    .pop_data  (o_out),
    .count     (o_count)
  );

  assign m_tvalid = o_count != '0;
  assign o_pop    = m_tvalid && m_tready;
  assign m_tdata  = {4'b0000, o_out.pulses_seen, o_out.new_pulse, o_out.current_bin,
                     o_out.in_window, o_out.bin_count, o_out.bin_sum};

endmodule
